// ===== src/hdkp_pkg.sv =====
package hdkp_pkg;

  // Path geometry
  localparam int MAX_DEPTH   = 10;
  localparam int HEAD_DEPTH  = 5;
  localparam int HEAD_IDX_W  = 3;
  localparam int COUNT_W     = 5;
  localparam int WORD_W      = 32;
  localparam int CLASS_W     = 4;
  localparam int LIMIT_W     = 31;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;
  localparam logic [COUNT_W-1:0] DEPTH_LIM = COUNT_W'(MAX_DEPTH);
  localparam logic [COUNT_W-1:0] HEAD_LIM  = COUNT_W'(HEAD_DEPTH);

  // Front to back queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_CNT_W = 2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACCOUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ADDRESS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_POOL_KEY = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_POLICY   = 2'd3;

  localparam logic [LIMIT_W-1:0] RST_MAX_ACCOUNT  = 31'd100;
  localparam logic [WORD_W-1:0]  RST_MAX_ADDRESS  = 32'd1000000;
  localparam logic [LIMIT_W-1:0] RST_MAX_POOL_KEY = 31'd1000000;
  localparam logic [LIMIT_W-1:0] RST_MAX_POLICY   = 31'd1000000;

  // Path classes
  localparam logic [CLASS_W-1:0] CLS_INVALID     = 4'd0;
  localparam logic [CLASS_W-1:0] CLS_ACCOUNT     = 4'd1;
  localparam logic [CLASS_W-1:0] CLS_PAYMENT     = 4'd2;
  localparam logic [CLASS_W-1:0] CLS_STAKING     = 4'd3;
  localparam logic [CLASS_W-1:0] CLS_DREP        = 4'd4;
  localparam logic [CLASS_W-1:0] CLS_CC_COLD     = 4'd5;
  localparam logic [CLASS_W-1:0] CLS_CC_HOT      = 4'd6;
  localparam logic [CLASS_W-1:0] CLS_MS_ACCOUNT  = 4'd7;
  localparam logic [CLASS_W-1:0] CLS_MS_PAYMENT  = 4'd8;
  localparam logic [CLASS_W-1:0] CLS_MS_STAKING  = 4'd9;
  localparam logic [CLASS_W-1:0] CLS_MINT        = 4'd10;
  localparam logic [CLASS_W-1:0] CLS_POOL_COLD   = 4'd11;
  localparam logic [CLASS_W-1:0] CLS_VOTE_ACCT   = 4'd12;
  localparam logic [CLASS_W-1:0] CLS_VOTE_KEY    = 4'd13;

  // Path element constants
  localparam logic [WORD_W-1:0] HARD_BIT        = 32'h8000_0000;
  localparam logic [WORD_W-1:0] PURPOSE_LEGACY  = 32'h8000_0000 | 32'd44;
  localparam logic [WORD_W-1:0] PURPOSE_ORD     = 32'h8000_0000 | 32'd1852;
  localparam logic [WORD_W-1:0] PURPOSE_MULTI   = 32'h8000_0000 | 32'd1854;
  localparam logic [WORD_W-1:0] PURPOSE_POLICY  = 32'h8000_0000 | 32'd1855;
  localparam logic [WORD_W-1:0] PURPOSE_POOL    = 32'h8000_0000 | 32'd1853;
  localparam logic [WORD_W-1:0] PURPOSE_VOTE    = 32'h8000_0000 | 32'd1694;
  localparam logic [WORD_W-1:0] COIN_TYPE       = 32'h8000_0000 | 32'd1815;

  localparam logic [WORD_W-1:0] CHAIN_EXTERNAL  = 32'd0;
  localparam logic [WORD_W-1:0] CHAIN_INTERNAL  = 32'd1;
  localparam logic [WORD_W-1:0] CHAIN_STAKING   = 32'd2;
  localparam logic [WORD_W-1:0] CHAIN_DREP      = 32'd3;
  localparam logic [WORD_W-1:0] CHAIN_CC_COLD   = 32'd4;
  localparam logic [WORD_W-1:0] CHAIN_CC_HOT    = 32'd5;

  // One complete path handed from front to back
  typedef struct packed {
    logic [HEAD_DEPTH-1:0][WORD_W-1:0] words;
    logic [COUNT_W-1:0]                len;
  } hdkp_job_t;

endpackage

// ===== src/hdkp_front.sv =====
module hdkp_front
  import hdkp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [WORD_W-1:0] path_word,
  input  logic              last_word,
  output logic              push,
  output hdkp_job_t         job
);

  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [WORD_W-1:0]  head_r [HEAD_DEPTH];
  logic [COUNT_W-1:0] count_inc;
  logic               head_wr;

  assign head_wr   = accept && (count_r < HEAD_LIM);
  assign count_inc = (count_r < COUNT_MAX) ? count_r + 5'd1 : count_r;

  // Saturating count, cleared at the end of each path
  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      count_nxt = last_word ? '0 : count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // First words of the path
  always_ff @(posedge clk) begin
    if (head_wr) begin
      head_r[count_r[HEAD_IDX_W-1:0]] <= path_word;
    end
  end

  // Snapshot including the word arriving now
  always_comb begin
    for (int i = 0; i < HEAD_DEPTH; i++) begin
      job.words[i] = (head_wr && count_r == COUNT_W'(i)) ? path_word : head_r[i];
    end
    job.len = count_inc;
  end

  assign push = accept && last_word;

endmodule

// ===== src/hdkp_queue.sv =====
module hdkp_queue
  import hdkp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  hdkp_job_t push_job,
  input  logic      pop,
  output hdkp_job_t pop_job,
  output logic      empty,
  output logic      full
);

  hdkp_job_t              slot_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                   do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = slot_r[rd_ptr_r];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== src/hdkp_back.sv =====
module hdkp_back
  import hdkp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 job_valid,
  input  hdkp_job_t            job,
  output logic                 pop,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  output logic                 out_valid,
  output logic [CLASS_W-1:0]   out_path_class,
  output logic                 out_reasonable,
  output logic                 out_multidelegation,
  output logic                 out_too_long
);

  logic [LIMIT_W-1:0] max_account_r, max_pool_key_r, max_policy_r;
  logic [WORD_W-1:0]  max_address_r;

  logic               valid_r;
  logic [CLASS_W-1:0] class_r, cls;
  logic               reas_r, reas;
  logic               multi_r, multi;
  logic               long_r, too_long;

  logic [WORD_W-1:0]  w0, w1, acct, chain, addr;
  logic [COUNT_W-1:0] len;
  logic               coin_ok, pre_legacy, pre_ord, pre_multi;
  logic               pre_mint, pre_pool, pre_vote;
  logic               acct_ok, addr_ok;

  // Limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_account_r  <= RST_MAX_ACCOUNT;
      max_address_r  <= RST_MAX_ADDRESS;
      max_pool_key_r <= RST_MAX_POOL_KEY;
      max_policy_r   <= RST_MAX_POLICY;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_ACCOUNT:  max_account_r  <= cfg_data[LIMIT_W-1:0];
        CFG_MAX_ADDRESS:  max_address_r  <= cfg_data;
        CFG_MAX_POOL_KEY: max_pool_key_r <= cfg_data[LIMIT_W-1:0];
        CFG_MAX_POLICY:   max_policy_r   <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign pop   = job_valid;
  assign w0    = job.words[0];
  assign w1    = job.words[1];
  assign acct  = job.words[2];
  assign chain = job.words[3];
  assign addr  = job.words[4];
  assign len   = job.len;

  // Purpose and coin prefixes
  assign coin_ok    = (len >= 5'd2) && (w1 == COIN_TYPE);
  assign pre_legacy = coin_ok && (w0 == PURPOSE_LEGACY);
  assign pre_ord    = coin_ok && (w0 == PURPOSE_ORD);
  assign pre_multi  = coin_ok && (w0 == PURPOSE_MULTI);
  assign pre_mint   = coin_ok && (w0 == PURPOSE_POLICY);
  assign pre_pool   = coin_ok && (w0 == PURPOSE_POOL);
  assign pre_vote   = coin_ok && (w0 == PURPOSE_VOTE);
  assign too_long   = (len > DEPTH_LIM);

  // Class decode; chain selects on its low byte, then non-payment cases check the full word
  always_comb begin
    cls = CLS_INVALID;
    if (pre_legacy || pre_ord) begin
      if (len >= 5'd3 && acct[WORD_W-1]) begin
        if (len == 5'd3) begin
          cls = CLS_ACCOUNT;
        end else if (len == 5'd5) begin
          case (chain[7:0])
            CHAIN_EXTERNAL[7:0], CHAIN_INTERNAL[7:0]: cls = CLS_PAYMENT;
            CHAIN_STAKING[7:0]: begin
              if (pre_ord && chain == CHAIN_STAKING && !addr[WORD_W-1]) cls = CLS_STAKING;
            end
            CHAIN_DREP[7:0]: begin
              if (pre_ord && chain == CHAIN_DREP && !addr[WORD_W-1]) cls = CLS_DREP;
            end
            CHAIN_CC_COLD[7:0]: begin
              if (pre_ord && chain == CHAIN_CC_COLD && !addr[WORD_W-1]) cls = CLS_CC_COLD;
            end
            CHAIN_CC_HOT[7:0]: begin
              if (pre_ord && chain == CHAIN_CC_HOT && !addr[WORD_W-1]) cls = CLS_CC_HOT;
            end
            default: cls = CLS_INVALID;
          endcase
        end
      end
    end else if (pre_multi) begin
      if (len >= 5'd3 && acct[WORD_W-1]) begin
        if (len == 5'd3) begin
          cls = CLS_MS_ACCOUNT;
        end else if (len == 5'd5) begin
          case (chain[7:0])
            CHAIN_EXTERNAL[7:0]: begin
              if (!addr[WORD_W-1]) cls = CLS_MS_PAYMENT;
            end
            CHAIN_STAKING[7:0]: begin
              if (chain == CHAIN_STAKING && !addr[WORD_W-1]) cls = CLS_MS_STAKING;
            end
            default: cls = CLS_INVALID;
          endcase
        end
      end
    end else if (pre_mint) begin
      if (len == 5'd3 && acct[WORD_W-1]) cls = CLS_MINT;
    end else if (pre_pool) begin
      if (len == 5'd4 && acct == HARD_BIT && chain[WORD_W-1]) cls = CLS_POOL_COLD;
    end else if (pre_vote) begin
      if (len >= 5'd3 && acct[WORD_W-1]) begin
        if (len == 5'd3) begin
          cls = CLS_VOTE_ACCT;
        end else if (len == 5'd5 && chain == CHAIN_EXTERNAL && !addr[WORD_W-1]) begin
          cls = CLS_VOTE_KEY;
        end
      end
    end
    if (too_long) cls = CLS_INVALID;
  end

  // Limit checks per class
  assign acct_ok = acct[WORD_W-1] && (acct[LIMIT_W-1:0] <= max_account_r);
  assign addr_ok = (addr <= max_address_r);

  always_comb begin
    case (cls)
      CLS_ACCOUNT, CLS_MS_ACCOUNT, CLS_VOTE_ACCT: reas = acct_ok;
      CLS_PAYMENT, CLS_STAKING, CLS_MS_PAYMENT, CLS_MS_STAKING, CLS_VOTE_KEY:
        reas = acct_ok && addr_ok;
      CLS_DREP, CLS_CC_COLD, CLS_CC_HOT:
        reas = acct_ok && addr_ok && (addr == '0);
      CLS_MINT:      reas = (acct[LIMIT_W-1:0] <= max_policy_r);
      CLS_POOL_COLD: reas = (chain[LIMIT_W-1:0] <= max_pool_key_r);
      default:       reas = 1'b0;
    endcase
  end

  assign multi = ((cls == CLS_STAKING) || (cls == CLS_MS_STAKING)) && (addr != '0);

  // Result strobe and word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid) begin
      class_r <= cls;
      reas_r  <= reas;
      multi_r <= multi;
      long_r  <= too_long;
    end
  end

  assign out_valid           = valid_r;
  assign out_path_class      = class_r;
  assign out_reasonable      = reas_r;
  assign out_multidelegation = multi_r;
  assign out_too_long        = long_r;

endmodule

// ===== src/hd_key_path_classifier.sv =====
// Key path classifier.
// Input: one path element per word on in_path_word, in_last_word marking the
// final element. A word is taken at a rising edge with start high and busy low.
// Words without the last marker only fill the head store and bump the count.
// Output: for each last word, one result word on out_path_class, out_reasonable,
// out_multidelegation and out_too_long, marked by out_valid for one cycle.
// The receiver has no stall; results must be taken as they appear.
// The front snapshot of the path goes into the queue with its last word, and
// the back classify register then holds the result and raises the strobe.
// Throughput: one word per cycle; the front hands a finished path to a
// two-entry queue and the back drains one path per cycle, so busy stays low
// in steady use and rises only if the queue were full.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 max_account,
// 1 max_address, 2 max_pool_key_index, 3 max_policy_index) and cfg_data;
// cfg_ready is always high. Write limits only while no path is in flight.
// Reset (rst_n low, synchronous) clears the count, the queue and the strobe
// and loads the default limits; no clearing pass is needed.
module hd_key_path_classifier
  import hdkp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [WORD_W-1:0]    in_path_word,
  input  logic                 in_last_word,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  output logic                 out_valid,
  output logic [CLASS_W-1:0]   out_path_class,
  output logic                 out_reasonable,
  output logic                 out_multidelegation,
  output logic                 out_too_long
);

  logic      accept, push, pop, q_empty, q_full;
  hdkp_job_t front_job, back_job;

  assign busy      = q_full;
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  hdkp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .path_word (in_path_word),
    .last_word (in_last_word),
    .push      (push),
    .job       (front_job)
  );

  hdkp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (front_job),
    .pop      (pop),
    .pop_job  (back_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  hdkp_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .job_valid           (!q_empty),
    .job                 (back_job),
    .pop                 (pop),
    .cfg_we              (cfg_valid && cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .out_valid           (out_valid),
    .out_path_class      (out_path_class),
    .out_reasonable      (out_reasonable),
    .out_multidelegation (out_multidelegation),
    .out_too_long        (out_too_long)
  );

endmodule

// ===== tb/sv/hd_key_path_classifier_test.sv =====
module hd_key_path_classifier_test;
  import hdkp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF    = 6;
  localparam int RST_CYCLES  = 9;
  localparam int NUM_DIR     = 26;
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_WORDS = 75;
  localparam int SETTLE      = 6;

  typedef struct packed {
    logic [CLASS_W-1:0] cls;
    logic               ok;
    logic               mdl;
    logic               tl;
  } path_result_t;

  // One directed path: length, the five head words, and an optional typed result
  typedef struct {
    int           len;
    logic [31:0]  w0, w1, w2, w3, w4;
    bit           typed;
    path_result_t res;
  } dir_path_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [WORD_W-1:0]    in_path_word = '0;
  logic                 in_last_word = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0]    cfg_data = '0;
  logic                 out_valid;
  logic [CLASS_W-1:0]   out_path_class;
  logic                 out_reasonable;
  logic                 out_multidelegation;
  logic                 out_too_long;

  // Path model state and limits
  logic [WORD_W-1:0]  path_head [HEAD_DEPTH];
  logic [COUNT_W-1:0] path_len;
  logic [LIMIT_W-1:0] lim_account;
  logic [WORD_W-1:0]  lim_address;
  logic [LIMIT_W-1:0] lim_pool;
  logic [LIMIT_W-1:0] lim_policy;

  path_result_t      expected_classes [$];
  logic [WORD_W-1:0] path_words [$];
  int                errors = 0;
  int                idle_pct = 0;

  dir_path_t dir_paths [NUM_DIR] = '{
    '{1, PURPOSE_LEGACY, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, '{CLS_INVALID, 1'b0, 1'b0, 1'b0}},
    '{3, PURPOSE_ORD, COIN_TYPE, HARD_BIT, 32'd0, 32'd0, 1'b1,
      '{CLS_ACCOUNT, 1'b1, 1'b0, 1'b0}},
    '{5, PURPOSE_ORD, COIN_TYPE, HARD_BIT, CHAIN_EXTERNAL, 32'd0, 1'b1,
      '{CLS_PAYMENT, 1'b1, 1'b0, 1'b0}},
    '{5, PURPOSE_LEGACY, COIN_TYPE, HARD_BIT | 32'd7, CHAIN_INTERNAL, 32'd999999, 1'b0,
      '{CLS_INVALID, 1'b0, 1'b0, 1'b0}},
    '{5, PURPOSE_ORD, COIN_TYPE, HARD_BIT, CHAIN_STAKING, 32'd1, 1'b1,
      '{CLS_STAKING, 1'b1, 1'b1, 1'b0}},
    // staking under the legacy purpose is not a staking path
    '{5, PURPOSE_LEGACY, COIN_TYPE, HARD_BIT, CHAIN_STAKING, 32'd0, 1'b0,
      '{CLS_INVALID, 1'b0, 1'b0, 1'b0}},
    '{5, PURPOSE_ORD, COIN_TYPE, HARD_BIT, CHAIN_DREP, 32'd0, 1'b0,
      '{CLS_INVALID, 1'b0, 1'b0, 1'b0}},
    '{5, PURPOSE_ORD, COIN_TYPE, HARD_BIT, CHAIN_CC_COLD, 32'd0, 1'b0,
      '{CLS_INVALID, 1'b0, 1'b0, 1'b0}},
    '{5, PURPOSE_ORD, COIN_TYPE, HARD_BIT, CHAIN_CC_HOT, 32'd1, 1'b0,
      '{CLS_INVALID, 1'b0, 1'b0, 1'b0}},
    // low byte says staking, full chain does not
    '{5, PURPOSE_ORD, COIN_TYPE, HARD_BIT, 32'h0000_0102, 32'd0, 1'b0,
      '{CLS_INVALID, 1'b0, 1'b0, 1'b0}},
    // low byte truncation makes this a payment path
    '{5, PURPOSE_ORD, COIN_TYPE, HARD_BIT, 32'h0000_0100, 32'd0, 1'b0,
      '{CLS_INVALID, 1'b0, 1'b0, 1'b0}},
    '{3, PURPOSE_MULTI, COIN_TYPE, HARD_BIT | 32'd100, 32'd0, 32'd0, 1'b0,
      '{CLS_INVALID, 1'b0, 1'b0, 1'b0}},
    '{5, PURPOSE_MULTI, COIN_TYPE, HARD_BIT, CHAIN_EXTERNAL, 32'd5, 1'b0,
      '{CLS_INVALID, 1'b0, 1'b0, 1'b0}},
    '{5, PURPOSE_MULTI, COIN_TYPE, HARD_BIT, CHAIN_STAKING, 32'd3, 1'b0,
      '{CLS_INVALID, 1'b0, 1'b0, 1'b0}},
    '{3, PURPOSE_POLICY, COIN_TYPE, HARD_BIT | 32'd5, 32'd0, 32'd0, 1'b0,
      '{CLS_INVALID, 1'b0, 1'b0, 1'b0}},
    '{4, PURPOSE_POOL, COIN_TYPE, HARD_BIT, HARD_BIT | 32'd3, 32'd0, 1'b0,
      '{CLS_INVALID, 1'b0, 1'b0, 1'b0}},
    '{3, PURPOSE_VOTE, COIN_TYPE, HARD_BIT, 32'd0, 32'd0, 1'b0,
      '{CLS_INVALID, 1'b0, 1'b0, 1'b0}},
    '{5, PURPOSE_VOTE, COIN_TYPE, HARD_BIT, 32'd0, 32'd0, 1'b0,
      '{CLS_INVALID, 1'b0, 1'b0, 1'b0}},
    // largest account index, over the limit
    '{3, PURPOSE_ORD, COIN_TYPE, 32'hFFFF_FFFF, 32'd0, 32'd0, 1'b1,
      '{CLS_ACCOUNT, 1'b0, 1'b0, 1'b0}},
    '{5, PURPOSE_ORD, COIN_TYPE, HARD_BIT, CHAIN_EXTERNAL, 32'hFFFF_FFFF, 1'b1,
      '{CLS_PAYMENT, 1'b0, 1'b0, 1'b0}},
    // exactly the maximum depth, then one over, then count saturation
    '{10, PURPOSE_ORD, COIN_TYPE, HARD_BIT, 32'd0, 32'd0, 1'b1,
      '{CLS_INVALID, 1'b0, 1'b0, 1'b0}},
    '{11, PURPOSE_ORD, COIN_TYPE, HARD_BIT, 32'd0, 32'd0, 1'b1,
      '{CLS_INVALID, 1'b0, 1'b0, 1'b1}},
    '{36, PURPOSE_ORD, COIN_TYPE, HARD_BIT, 32'd0, 32'd0, 1'b1,
      '{CLS_INVALID, 1'b0, 1'b0, 1'b1}},
    '{2, PURPOSE_ORD, COIN_TYPE, 32'd0, 32'd0, 32'd0, 1'b0,
      '{CLS_INVALID, 1'b0, 1'b0, 1'b0}},
    '{5, PURPOSE_ORD, COIN_TYPE, HARD_BIT, CHAIN_EXTERNAL, 32'd0, 1'b1,
      '{CLS_PAYMENT, 1'b1, 1'b0, 1'b0}},
    // hardened address kills a multisig payment path
    '{5, PURPOSE_MULTI, COIN_TYPE, HARD_BIT, CHAIN_EXTERNAL, HARD_BIT, 1'b0,
      '{CLS_INVALID, 1'b0, 1'b0, 1'b0}}
  };

  hd_key_path_classifier u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_path_word        (in_path_word),
    .in_last_word        (in_last_word),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .out_valid           (out_valid),
    .out_path_class      (out_path_class),
    .out_reasonable      (out_reasonable),
    .out_multidelegation (out_multidelegation),
    .out_too_long        (out_too_long)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Path model
  // ---------------------------------------------------------------------------
  function automatic bit has_prefix(int unsigned len, logic [WORD_W-1:0] purpose);
    return len >= 2 && path_head[0] == purpose && path_head[1] == COIN_TYPE;
  endfunction

  function automatic logic [CLASS_W-1:0] classify_path(int unsigned len);
    logic [WORD_W-1:0] acct;
    logic [WORD_W-1:0] chain;
    logic [WORD_W-1:0] addr;
    bit                ord;
    acct  = path_head[2];
    chain = path_head[3];
    addr  = path_head[4];
    ord   = has_prefix(len, PURPOSE_ORD);

    // ordinary and legacy: chain picked by its low byte, then checked in full unless payment
    if (ord || has_prefix(len, PURPOSE_LEGACY)) begin
      if (len < 3 || !acct[31]) return CLS_INVALID;
      if (len == 3) return CLS_ACCOUNT;
      if (len != 5) return CLS_INVALID;
      case (chain[7:0])
        CHAIN_EXTERNAL[7:0], CHAIN_INTERNAL[7:0]: return CLS_PAYMENT;
        CHAIN_STAKING[7:0]:
          return (ord && chain == CHAIN_STAKING && !addr[31]) ? CLS_STAKING : CLS_INVALID;
        CHAIN_DREP[7:0]:
          return (ord && chain == CHAIN_DREP && !addr[31]) ? CLS_DREP : CLS_INVALID;
        CHAIN_CC_COLD[7:0]:
          return (ord && chain == CHAIN_CC_COLD && !addr[31]) ? CLS_CC_COLD : CLS_INVALID;
        CHAIN_CC_HOT[7:0]:
          return (ord && chain == CHAIN_CC_HOT && !addr[31]) ? CLS_CC_HOT : CLS_INVALID;
        default: return CLS_INVALID;
      endcase
    end
    if (has_prefix(len, PURPOSE_MULTI)) begin
      if (len < 3 || !acct[31]) return CLS_INVALID;
      if (len == 3) return CLS_MS_ACCOUNT;
      if (len != 5) return CLS_INVALID;
      case (chain[7:0])
        CHAIN_EXTERNAL[7:0]: return addr[31] ? CLS_INVALID : CLS_MS_PAYMENT;
        CHAIN_STAKING[7:0]:
          return (chain == CHAIN_STAKING && !addr[31]) ? CLS_MS_STAKING : CLS_INVALID;
        default: return CLS_INVALID;
      endcase
    end
    if (has_prefix(len, PURPOSE_POLICY))
      return (len == 3 && acct[31]) ? CLS_MINT : CLS_INVALID;
    if (has_prefix(len, PURPOSE_POOL))
      return (len == 4 && acct == HARD_BIT && chain[31]) ? CLS_POOL_COLD : CLS_INVALID;
    if (has_prefix(len, PURPOSE_VOTE)) begin
      if (len < 3 || !acct[31]) return CLS_INVALID;
      if (len == 3) return CLS_VOTE_ACCT;
      if (len != 5) return CLS_INVALID;
      return (chain == CHAIN_EXTERNAL && !addr[31]) ? CLS_VOTE_KEY : CLS_INVALID;
    end
    return CLS_INVALID;
  endfunction

  function automatic bit limits_met(logic [CLASS_W-1:0] cls);
    bit                acct_in;
    logic [WORD_W-1:0] addr;
    addr    = path_head[4];
    acct_in = path_head[2][31] && (path_head[2][30:0] <= lim_account);
    case (cls)
      CLS_ACCOUNT, CLS_MS_ACCOUNT, CLS_VOTE_ACCT: return acct_in;
      CLS_PAYMENT, CLS_STAKING, CLS_MS_PAYMENT, CLS_MS_STAKING, CLS_VOTE_KEY:
        return acct_in && addr <= lim_address;
      CLS_DREP, CLS_CC_COLD, CLS_CC_HOT:
        return acct_in && addr <= lim_address && addr == '0;
      CLS_MINT:      return path_head[2][30:0] <= lim_policy;
      CLS_POOL_COLD: return path_head[3][30:0] <= lim_pool;
      default:       return 1'b0;
    endcase
  endfunction

  task automatic track_path_word(input logic [WORD_W-1:0] w, input logic fin,
                                 output bit emit, output path_result_t r);
    int unsigned len;
    if (path_len < HEAD_LIM) path_head[path_len] = w;
    if (path_len < COUNT_MAX) path_len++;
    emit = fin;
    r    = '0;
    if (fin) begin
      len      = path_len;
      path_len = '0;
      r.tl     = len > MAX_DEPTH;
      if (!r.tl) begin
        r.cls = classify_path(len);
        r.ok  = limits_met(r.cls);
        r.mdl = (r.cls == CLS_STAKING || r.cls == CLS_MS_STAKING) && path_head[4] != '0;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < idle_pct) return $urandom_range(1, 4);
    return 0;
  endfunction

  task automatic send_word(input logic [WORD_W-1:0] w, input logic fin, input int gap,
                           input bit typed, input path_result_t typed_res);
    bit           emit;
    path_result_t r;
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start        <= 1'b1;
    in_path_word <= w;
    in_last_word <= fin;
    do @(posedge clk); while (busy);
    track_path_word(w, fin, emit, r);
    if (emit) expected_classes.push_back(typed ? typed_res : r);
  endtask

  task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MAX_ACCOUNT:  lim_account = data[LIMIT_W-1:0];
      CFG_MAX_ADDRESS:  lim_address = data;
      CFG_MAX_POOL_KEY: lim_pool    = data[LIMIT_W-1:0];
      CFG_MAX_POLICY:   lim_policy  = data[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_limits(input logic [WORD_W-1:0] acct, input logic [WORD_W-1:0] addr,
                            input logic [WORD_W-1:0] pool, input logic [WORD_W-1:0] policy);
    write_limit(CFG_MAX_ACCOUNT, acct);
    write_limit(CFG_MAX_ADDRESS, addr);
    write_limit(CFG_MAX_POOL_KEY, pool);
    write_limit(CFG_MAX_POLICY, policy);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stop sending and wait until every pending result word has come back
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (expected_classes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Index near a limit, at zero, small, or anywhere
  function automatic logic [WORD_W-1:0] pick_index(logic [WORD_W-1:0] lim);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return lim;
      2: return lim + 1;
      3: return lim - 1;
      4: return $urandom_range(0, 16);
      default: return $urandom;
    endcase
  endfunction

  // Build one random path into path_words: mostly well-formed prefixes
  task automatic make_path();
    int                len;
    logic [WORD_W-1:0] purpose;
    logic [WORD_W-1:0] coin;
    logic [WORD_W-1:0] acct;
    logic [WORD_W-1:0] chain;
    logic [WORD_W-1:0] addr;
    path_words.delete();

    // pure noise
    if ($urandom_range(0, 99) < 12) begin
      len = $urandom_range(1, 12);
      repeat (len) path_words.push_back($urandom);
      return;
    end

    case ($urandom_range(0, 7))
      0: purpose = PURPOSE_LEGACY;
      1, 6: purpose = PURPOSE_ORD;
      2: purpose = PURPOSE_MULTI;
      3: purpose = PURPOSE_POLICY;
      4: purpose = PURPOSE_POOL;
      5: purpose = PURPOSE_VOTE;
      default: purpose = $urandom_range(0, 1) ? $urandom : (HARD_BIT | $urandom_range(0, 2000));
    endcase
    coin = ($urandom_range(0, 15) == 0) ? (COIN_TYPE ^ (32'd1 << $urandom_range(0, 31)))
                                        : COIN_TYPE;

    // account element
    if (purpose == PURPOSE_POOL && $urandom_range(0, 3) != 0) begin
      acct = HARD_BIT;
    end else begin
      acct = pick_index(purpose == PURPOSE_POLICY ? {1'b0, lim_policy} : {1'b0, lim_account});
      acct = {($urandom_range(0, 99) < 85), acct[30:0]};
    end

    // chain element
    if (purpose == PURPOSE_POOL) begin
      chain = pick_index({1'b0, lim_pool});
      chain = {($urandom_range(0, 4) != 0), chain[30:0]};
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: chain = $urandom_range(0, 5);
        6: chain = ($urandom_range(1, 255) << 8) | $urandom_range(0, 5);
        7: chain = $urandom;
        8: chain = HARD_BIT | $urandom_range(0, 5);
        default: chain = $urandom_range(0, 5);
      endcase
    end

    addr = pick_index(lim_address);
    if ($urandom_range(0, 7) == 0) addr[31] = 1'b1;

    case ($urandom_range(0, 19))
      0: len = 1;
      1: len = 2;
      2, 3, 4, 5: len = 3;
      6, 7: len = 4;
      16, 17, 18: len = $urandom_range(6, 11);
      19: len = $urandom_range(12, 35);
      default: len = 5;
    endcase
    if (purpose == PURPOSE_POLICY && $urandom_range(0, 1)) len = 3;
    if (purpose == PURPOSE_POOL && $urandom_range(0, 1)) len = 4;

    for (int i = 0; i < len; i++) begin
      case (i)
        0: path_words.push_back(purpose);
        1: path_words.push_back(coin);
        2: path_words.push_back(acct);
        3: path_words.push_back(chain);
        4: path_words.push_back(addr);
        default: path_words.push_back($urandom);
      endcase
    end
  endtask

  function automatic logic [WORD_W-1:0] dir_word(dir_path_t p, int j);
    case (j)
      0: return p.w0;
      1: return p.w1;
      2: return p.w2;
      3: return p.w3;
      4: return p.w4;
      default: return j[0] ? 32'hFFFF_FFFF : 32'h0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    path_result_t want;
    if (rst_n && out_valid) begin
      if (expected_classes.size() == 0) begin
        $error("result word with no path pending");
        errors++;
      end else begin
        want = expected_classes.pop_front();
        if (out_path_class !== want.cls) begin
          $error("path_class: expected %0d, actual %0d", want.cls, out_path_class);
          errors++;
        end
        if (out_reasonable !== want.ok) begin
          $error("reasonable: expected %0d, actual %0d", want.ok, out_reasonable);
          errors++;
        end
        if (out_multidelegation !== want.mdl) begin
          $error("multidelegation: expected %0d, actual %0d", want.mdl, out_multidelegation);
          errors++;
        end
        if (out_too_long !== want.tl) begin
          $error("too_long: expected %0d, actual %0d", want.tl, out_too_long);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    int        sent;
    int        cfg_kind;
    dir_path_t row;
    path_result_t none;
    none = '0;

    // model reset state
    for (int i = 0; i < HEAD_DEPTH; i++) path_head[i] = '0;
    path_len    = '0;
    lim_account = RST_MAX_ACCOUNT;
    lim_address = RST_MAX_ADDRESS;
    lim_pool    = RST_MAX_POOL_KEY;
    lim_policy  = RST_MAX_POLICY;

    repeat (RST_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // directed paths with reset limits, back to back
    idle_pct = 0;
    for (int i = 0; i < NUM_DIR; i++) begin
      row = dir_paths[i];
      for (int j = 0; j < row.len; j++)
        send_word(dir_word(row, j), j == row.len - 1, pick_gap(), row.typed, row.res);
    end
    drain();

    // random phases, each with its own limits and idle rate
    for (int p = 0; p < NUM_PHASES; p++) begin
      cfg_kind = p % 4;
      case (cfg_kind)
        0: set_limits(32'(RST_MAX_ACCOUNT), RST_MAX_ADDRESS, 32'(RST_MAX_POOL_KEY),
                      32'(RST_MAX_POLICY));
        1: set_limits('0, '0, '0, '0);
        2: set_limits('1, '1, '1, '1);
        default: set_limits($urandom_range(0, 300), $urandom, $urandom_range(0, 5000),
                            $urandom);
      endcase
      case ((p + p / 4) % 3)
        0: idle_pct = 0;
        1: idle_pct = 69;
        default: idle_pct = 27;
      endcase

      sent = 0;
      while (sent < PHASE_WORDS) begin
        make_path();
        foreach (path_words[j])
          send_word(path_words[j], j == path_words.size() - 1, pick_gap(), 1'b0, none);
        sent += path_words.size();
      end
      drain();
    end

    if (errors == 0 && expected_classes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run
  initial begin
    #(CLK_HALF * 2 * 200_000);
    $display("status: fail");
    $finish;
  end

endmodule
